// ===== rtl/lwi_pkg.sv =====
// shared constants and types of the linear image warp unit
package lwi_pkg;

    localparam int DEF_MAX_WIDTH = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DIST_FLOOR = 656;

    localparam int COEF_W = 20;
    localparam int SIZE_W = 10;
    localparam int CFG_IDX_W = 3;
    localparam int DIST_W = 19;
    localparam int RECIP_W = 23;
    localparam int WEIGHT_W = 24;
    localparam int SUM_W = 26;
    localparam int ACC_W = 34;
    localparam int DIVD_W = 40;
    localparam int DIVS_W = 28;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_WARP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_RR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_RC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;

    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_MUL = 4'd1;
    localparam logic [3:0] OP_BOUND = 4'd2;
    localparam logic [3:0] OP_DIST = 4'd3;
    localparam logic [3:0] OP_DSTART = 4'd4;
    localparam logic [3:0] OP_DSAVE = 4'd5;
    localparam logic [3:0] OP_WEIGHT = 4'd6;
    localparam logic [3:0] OP_READ = 4'd7;
    localparam logic [3:0] OP_ACC = 4'd8;
    localparam logic [3:0] OP_FSTART = 4'd9;
    localparam logic [3:0] OP_RESULT = 4'd10;

    localparam logic [2:0] IDX_NEAREST = 3'd4;
    localparam logic [2:0] IDX_LAST = 3'd3;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] idx;
    } lwi_cmd_t;

    typedef struct packed {
        logic oob;
        logic sum_zero;
        logic div_done;
        logic out_free;
    } lwi_status_t;

endpackage

// ===== rtl/lwi_div.sv =====
// shared restoring divider, one quotient bit per cycle
module lwi_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lwi_pkg::DIVD_W-1:0] dividend,
    input  logic [lwi_pkg::DIVS_W-1:0] divisor,
    output logic [lwi_pkg::DIVD_W-1:0] quotient,
    output logic                       busy,
    output logic                       done
);
    import lwi_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVD_W - 1);

    logic [DIVD_W-1:0] q_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              bit_set;

    always_comb
    begin
        trial = {rem_reg, q_reg[DIVD_W-1]};
        diff = trial - {1'b0, dvs_reg};
        bit_set = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DIVD_W-2:0], bit_set};
            rem_reg <= bit_set ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
        end
    end

    assign quotient = q_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ===== rtl/lwi_datapath.sv =====
// datapath: configuration, image store, mapping, weights and output register
module lwi_datapath #(
    parameter int MAX_WIDTH = lwi_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lwi_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lwi_pkg::lwi_cmd_t             cmd,
    output lwi_pkg::lwi_status_t          status,
    input  logic                          load_en,
    input  logic                          capture,
    input  logic [8:0]                    pixel_row,
    input  logic [8:0]                    pixel_col,
    input  logic [7:0]                    pixel_in,
    input  logic                          cfg_valid,
    input  logic [lwi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lwi_pkg::COEF_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    pixel_out,
    output logic                          out_of_bounds
);
    import lwi_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = $clog2(DEPTH);

    logic signed [COEF_W-1:0] coef_rr_reg, coef_rc_reg, coef_cr_reg, coef_cc_reg;
    logic [SIZE_W-1:0] width_reg, height_reg;

    logic [7:0] mem [DEPTH];
    logic [7:0] mem_q;

    logic [8:0] row_reg, col_reg;
    logic signed [31:0] srow_reg, scol_reg;
    logic oob_reg;
    logic [RW-1:0] r1_reg, r2_reg, nr_reg;
    logic [CW-1:0] c1_reg, c2_reg, nc_reg;
    logic signed [DIST_W-1:0] dist_reg [4];
    logic [RECIP_W-1:0] recip_reg [4];
    logic [WEIGHT_W-1:0] w_reg [4];
    logic [SUM_W-1:0] sum_reg;
    logic [ACC_W-1:0] acc_reg;
    logic out_valid_reg;
    logic [7:0] pix_reg;
    logic oob_out_reg;

    logic [CW:0] w_eff;
    logic [RW:0] h_eff;
    logic [15:0] hl, wl, fr, fc, fnr, fnc;
    logic [31:0] nsum_r, nsum_c;
    logic [RW:0] r1p;
    logic [CW:0] c1p;
    logic signed [31:0] dr1, dr2, dc1, dc2;
    logic [8:0] opnd;
    logic signed [COEF_W-1:0] coef_sel;
    logic signed [29:0] prod;
    logic [RW-1:0] rd_row;
    logic [CW-1:0] rd_col;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic [DIVD_W-1:0] div_quot;
    logic div_busy, div_done;
    logic out_free;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = (CW+1)'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = (CW+1)'(MAX_WIDTH);
        else
            w_eff = (CW+1)'(width_reg);
        if (height_reg == '0)
            h_eff = (RW+1)'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = (RW+1)'(MAX_HEIGHT);
        else
            h_eff = (RW+1)'(height_reg);
        hl = 16'(h_eff - 1'b1);
        wl = 16'(w_eff - 1'b1);
        fr = srow_reg[31:16];
        fc = scol_reg[31:16];
        nsum_r = srow_reg + 32'sd32768;
        nsum_c = scol_reg + 32'sd32768;
        fnr = nsum_r[31:16];
        fnc = nsum_c[31:16];
        r1p = {1'b0, r1_reg} + 1'b1;
        c1p = {1'b0, c1_reg} + 1'b1;
        dc1 = scol_reg - $signed(32'(c1_reg) << 16);
        dc2 = $signed(32'(c2_reg) << 16) - scol_reg;
        dr1 = srow_reg - $signed(32'(r1_reg) << 16);
        dr2 = $signed(32'(r2_reg) << 16) - srow_reg;
    end

    always_comb
    begin
        case (cmd.idx[1:0])
            2'd0:
            begin
                opnd = row_reg;
                coef_sel = coef_rr_reg;
            end
            2'd1:
            begin
                opnd = col_reg;
                coef_sel = coef_cr_reg;
            end
            2'd2:
            begin
                opnd = row_reg;
                coef_sel = coef_rc_reg;
            end
            default:
            begin
                opnd = col_reg;
                coef_sel = coef_cc_reg;
            end
        endcase
        prod = $signed({1'b0, opnd}) * coef_sel;
    end

    always_comb
    begin
        case (cmd.idx)
            3'd0:
            begin
                rd_row = r1_reg;
                rd_col = c1_reg;
            end
            3'd1:
            begin
                rd_row = r1_reg;
                rd_col = c2_reg;
            end
            3'd2:
            begin
                rd_row = r2_reg;
                rd_col = c1_reg;
            end
            3'd3:
            begin
                rd_row = r2_reg;
                rd_col = c2_reg;
            end
            default:
            begin
                rd_row = nr_reg;
                rd_col = nc_reg;
            end
        endcase
        rd_addr = AW'(rd_row) * AW'(MAX_WIDTH) + AW'(rd_col);
        wr_addr = AW'(pixel_row) * AW'(MAX_WIDTH) + AW'(pixel_col);
    end

    always_comb
    begin
        if (cmd.op == OP_FSTART)
        begin
            div_dividend = DIVD_W'(acc_reg);
            div_divisor = DIVS_W'(sum_reg);
        end
        else
        begin
            div_dividend = DIVD_W'(64'h1_0000_0000);
            div_divisor = DIVS_W'(dist_reg[cmd.idx[1:0]]);
        end
    end

    lwi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    ((cmd.op == OP_DSTART) || (cmd.op == OP_FSTART)),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .busy     (div_busy),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_rr_reg <= COEF_W'(65536);
            coef_rc_reg <= '0;
            coef_cr_reg <= '0;
            coef_cc_reg <= COEF_W'(65536);
            width_reg <= SIZE_W'(512);
            height_reg <= SIZE_W'(512);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COEF_RR: coef_rr_reg <= cfg_data;
                CFG_COEF_RC: coef_rc_reg <= cfg_data;
                CFG_COEF_CR: coef_cr_reg <= cfg_data;
                CFG_COEF_CC: coef_cc_reg <= cfg_data;
                CFG_WIDTH: width_reg <= cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en && (32'(pixel_row) < MAX_HEIGHT) && (32'(pixel_col) < MAX_WIDTH))
            mem[wr_addr] <= pixel_in;
        if (cmd.op == OP_READ)
            mem_q <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            row_reg <= pixel_row;
            col_reg <= pixel_col;
        end
        case (cmd.op)
            OP_MUL:
            begin
                case (cmd.idx[1:0])
                    2'd0: srow_reg <= 32'(prod);
                    2'd1: srow_reg <= srow_reg + 32'(prod);
                    2'd2: scol_reg <= 32'(prod);
                    default: scol_reg <= scol_reg + 32'(prod);
                endcase
            end
            OP_BOUND:
            begin
                oob_reg <= (srow_reg < 0) || (srow_reg > $signed(32'(h_eff) << 16))
                    || (scol_reg < 0) || (scol_reg > $signed(32'(w_eff) << 16));
                r1_reg <= (fr > hl) ? hl[RW-1:0] : fr[RW-1:0];
                c1_reg <= (fc > wl) ? wl[CW-1:0] : fc[CW-1:0];
                nr_reg <= (fnr > hl) ? hl[RW-1:0] : fnr[RW-1:0];
                nc_reg <= (fnc > wl) ? wl[CW-1:0] : fnc[CW-1:0];
            end
            OP_DIST:
            begin
                r2_reg <= (16'(r1p) > hl) ? hl[RW-1:0] : r1p[RW-1:0];
                c2_reg <= (16'(c1p) > wl) ? wl[CW-1:0] : c1p[CW-1:0];
                dist_reg[0] <= dc1[DIST_W-1:0];
            end
            OP_DSTART:
            begin
                if (cmd.idx == 3'd0)
                begin
                    dist_reg[1] <= dc2[DIST_W-1:0];
                    dist_reg[2] <= dr1[DIST_W-1:0];
                    dist_reg[3] <= dr2[DIST_W-1:0];
                end
            end
            OP_DSAVE:
                recip_reg[cmd.idx[1:0]] <= (dist_reg[cmd.idx[1:0]] < DIST_FLOOR)
                    ? '0 : div_quot[RECIP_W-1:0];
            OP_WEIGHT:
            begin
                w_reg[0] <= WEIGHT_W'(recip_reg[0]) + WEIGHT_W'(recip_reg[2]);
                w_reg[1] <= WEIGHT_W'(recip_reg[1]) + WEIGHT_W'(recip_reg[2]);
                w_reg[2] <= WEIGHT_W'(recip_reg[0]) + WEIGHT_W'(recip_reg[3]);
                w_reg[3] <= WEIGHT_W'(recip_reg[1]) + WEIGHT_W'(recip_reg[3]);
                sum_reg <= SUM_W'(recip_reg[0]) * 2'd2 + SUM_W'(recip_reg[1]) * 2'd2
                    + SUM_W'(recip_reg[2]) * 2'd2 + SUM_W'(recip_reg[3]) * 2'd2;
                acc_reg <= '0;
            end
            OP_ACC:
                acc_reg <= acc_reg + ACC_W'(mem_q) * ACC_W'(w_reg[cmd.idx[1:0]]);
            default: ;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_RESULT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_RESULT)
        begin
            oob_out_reg <= oob_reg;
            if (oob_reg)
                pix_reg <= '0;
            else if (sum_reg == '0)
                pix_reg <= mem_q;
            else
                pix_reg <= div_quot[7:0];
        end
    end

    assign status.oob = oob_reg;
    assign status.sum_zero = (sum_reg == '0);
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    assign out_valid = out_valid_reg;
    assign pixel_out = pix_reg;
    assign out_of_bounds = oob_out_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == OP_DSTART) || (cmd.op == OP_FSTART)) |-> !div_busy)
        else $error("divider started while busy");
    a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RESULT) |-> out_free)
        else $error("result written over a pending one");
    a_acc_index: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_ACC) |-> (cmd.idx <= IDX_LAST) && (sum_reg != '0))
        else $error("bad accumulate step");

endmodule

// ===== rtl/lwi_ctrl.sv =====
// controller state machine sequencing the warp steps
module lwi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 command,
    output logic                 in_ready,
    output logic                 load_en,
    output logic                 capture,
    output lwi_pkg::lwi_cmd_t    cmd,
    input  lwi_pkg::lwi_status_t status
);
    import lwi_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL = 4'd1;
    localparam logic [3:0] S_BOUND = 4'd2;
    localparam logic [3:0] S_DIST = 4'd3;
    localparam logic [3:0] S_DSTART = 4'd4;
    localparam logic [3:0] S_DWAIT = 4'd5;
    localparam logic [3:0] S_DSAVE = 4'd6;
    localparam logic [3:0] S_WEIGHT = 4'd7;
    localparam logic [3:0] S_READ = 4'd8;
    localparam logic [3:0] S_ACC = 4'd9;
    localparam logic [3:0] S_FSTART = 4'd10;
    localparam logic [3:0] S_FWAIT = 4'd11;
    localparam logic [3:0] S_RESULT = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign load_en = accept && (command == CMD_LOAD);
    assign capture = accept;

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        cmd.op = OP_NONE;
        cmd.idx = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                k_next = '0;
                if (accept && (command == CMD_WARP))
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op = OP_MUL;
                k_next = k_reg + 1'b1;
                if (k_reg == IDX_LAST)
                    state_next = S_BOUND;
            end
            S_BOUND:
            begin
                cmd.op = OP_BOUND;
                k_next = '0;
                state_next = S_DIST;
            end
            S_DIST:
            begin
                cmd.op = OP_DIST;
                state_next = status.oob ? S_RESULT : S_DSTART;
            end
            S_DSTART:
            begin
                cmd.op = OP_DSTART;
                state_next = S_DWAIT;
            end
            S_DWAIT:
                if (status.div_done)
                    state_next = S_DSAVE;
            S_DSAVE:
            begin
                cmd.op = OP_DSAVE;
                k_next = k_reg + 1'b1;
                state_next = (k_reg == IDX_LAST) ? S_WEIGHT : S_DSTART;
            end
            S_WEIGHT:
            begin
                cmd.op = OP_WEIGHT;
                k_next = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                if (status.sum_zero)
                    cmd.idx = IDX_NEAREST;
                cmd.op = OP_READ;
                state_next = status.sum_zero ? S_RESULT : S_ACC;
            end
            S_ACC:
            begin
                cmd.op = OP_ACC;
                k_next = k_reg + 1'b1;
                state_next = (k_reg == IDX_LAST) ? S_FSTART : S_READ;
            end
            S_FSTART:
            begin
                cmd.op = OP_FSTART;
                state_next = S_FWAIT;
            end
            S_FWAIT:
                if (status.div_done)
                    state_next = S_RESULT;
            S_RESULT:
                if (status.out_free)
                begin
                    cmd.op = OP_RESULT;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
        end
    end

endmodule

// ===== rtl/linear_image_warp_interpolate_unit.sv =====
// top level of the linear image warp interpolation unit
// input channel: in_valid/in_ready with command, pixel_row, pixel_col, pixel_in.
// a load request (command 0) writes one pixel into the source store; a warp
// request (command 1) maps the row and column through the 2x2 matrix and
// blends the four neighbours.
// output channel: out_valid/out_ready with pixel_out and out_of_bounds, one
// result per warp request, none per load request.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// the user must write it only while no warp is in flight; the block does not enforce this.
// a warp inside the image runs four multiply steps, four reciprocals on the one
// shared radix-2 divider, eight read/accumulate steps and the final
// normalization on the same divider, each division giving a 40-bit quotient;
// when every weight is dropped the nearest pixel is taken in place of the
// accumulation and normalization, and out of bounds no division is done. one warp is worked at a time.
// results sit in an output register; the next request is taken while it waits,
// and the block holds its finished result only when the register is still full.
// reset restores the identity matrix and a 512 by 512 image; the source store
// is not cleared and must be loaded before it is read.
module linear_image_warp_interpolate_unit #(
    parameter int MAX_WIDTH = lwi_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lwi_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [8:0]                    pixel_row,
    input  logic [8:0]                    pixel_col,
    input  logic [7:0]                    pixel_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    pixel_out,
    output logic                          out_of_bounds,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lwi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lwi_pkg::COEF_W-1:0]    cfg_data
);
    import lwi_pkg::*;

    lwi_cmd_t    cmd;
    lwi_status_t status;
    logic        load_en;
    logic        capture;

    assign cfg_ready = 1'b1;

    lwi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .load_en  (load_en),
        .capture  (capture),
        .cmd      (cmd),
        .status   (status)
    );

    lwi_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .load_en       (load_en),
        .capture       (capture),
        .pixel_row     (pixel_row),
        .pixel_col     (pixel_col),
        .pixel_in      (pixel_in),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_out     (pixel_out),
        .out_of_bounds (out_of_bounds)
    );

endmodule

// ===== test/linear_image_warp_interpolate_unit_test.sv =====
// testbench of the linear image warp interpolation unit: scoreboard, stimulus and checks
`timescale 1ns / 1ps

module linear_image_warp_interpolate_unit_test;
    import lwi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int STORE_W = 512;
    localparam int STORE_H = 512;
    localparam int SETTLE = 300;

    class warp_scoreboard;
        logic [7:0] image_store [0:STORE_W*STORE_H-1];
        longint m_rr, m_rc, m_cr, m_cc;
        longint unsigned size_w, size_h;
        logic [7:0] want_pixel [$];
        logic want_oob [$];
        int errors;

        function new();
            m_rr = 65536;
            m_rc = 0;
            m_cr = 0;
            m_cc = 65536;
            size_w = 512;
            size_h = 512;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
            case (idx)
                CFG_COEF_RR: m_rr = longint'(signed'(data));
                CFG_COEF_RC: m_rc = longint'(signed'(data));
                CFG_COEF_CR: m_cr = longint'(signed'(data));
                CFG_COEF_CC: m_cc = longint'(signed'(data));
                CFG_WIDTH: size_w = data[SIZE_W-1:0];
                CFG_HEIGHT: size_h = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned eff(longint unsigned v, longint unsigned lim);
            if (v == 0)
                return 1;
            return (v > lim) ? lim : v;
        endfunction

        function longint unsigned inv_dist(longint d);
            if (d < DIST_FLOOR)
                return 0;
            return 64'h1_0000_0000 / longint'(d);
        endfunction

        function longint clip(longint v, longint last);
            return (v > last) ? last : v;
        endfunction

        function void note_request(logic cmd, logic [8:0] r, logic [8:0] c, logic [7:0] p);
            longint w, h, sr, sc, r1, r2, c1, c2, nr, nc;
            longint unsigned d1, d2, d3, d4, w1, w2, w3, w4, total, acc;
            if (cmd == CMD_LOAD)
            begin
                image_store[r*STORE_W+c] = p;
                return;
            end
            w = eff(size_w, STORE_W);
            h = eff(size_h, STORE_H);
            sr = longint'(r) * m_rr + longint'(c) * m_cr;
            sc = longint'(r) * m_rc + longint'(c) * m_cc;
            if (sr < 0 || sr > (h << 16) || sc < 0 || sc > (w << 16))
            begin
                want_pixel.push_back(8'd0);
                want_oob.push_back(1'b1);
                return;
            end
            r1 = clip(sr >>> 16, h - 1);
            r2 = clip(r1 + 1, h - 1);
            c1 = clip(sc >>> 16, w - 1);
            c2 = clip(c1 + 1, w - 1);
            d1 = inv_dist(sc - (c1 << 16));
            d2 = inv_dist((c2 << 16) - sc);
            d3 = inv_dist(sr - (r1 << 16));
            d4 = inv_dist((r2 << 16) - sr);
            w1 = d1 + d3;
            w2 = d2 + d3;
            w3 = d1 + d4;
            w4 = d2 + d4;
            total = w1 + w2 + w3 + w4;
            if (total == 0)
            begin
                nr = clip((sr + 32768) >>> 16, h - 1);
                nc = clip((sc + 32768) >>> 16, w - 1);
                want_pixel.push_back(image_store[nr*STORE_W+nc]);
            end
            else
            begin
                acc = image_store[r1*STORE_W+c1] * w1 + image_store[r1*STORE_W+c2] * w2
                    + image_store[r2*STORE_W+c1] * w3 + image_store[r2*STORE_W+c2] * w4;
                want_pixel.push_back(8'(acc / total));
            end
            want_oob.push_back(1'b0);
        endfunction

        function void check_result(logic [7:0] pix, logic oob);
            logic [7:0] ep;
            logic eo;
            if (want_pixel.size() == 0)
            begin
                $error("result with no request pending: pixel_out %0d out_of_bounds %0d",
                       pix, oob);
                errors++;
                return;
            end
            ep = want_pixel.pop_front();
            eo = want_oob.pop_front();
            if (pix !== ep)
            begin
                $error("pixel_out expected %0d actual %0d", ep, pix);
                errors++;
            end
            if (oob !== eo)
            begin
                $error("out_of_bounds expected %0d actual %0d", eo, oob);
                errors++;
            end
        endfunction

        function int pending();
            return want_pixel.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic command;
    logic [8:0] pixel_row;
    logic [8:0] pixel_col;
    logic [7:0] pixel_in;
    logic out_valid;
    logic out_ready;
    logic [7:0] pixel_out;
    logic out_of_bounds;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0] cfg_data;

    warp_scoreboard sb;
    int send_gap_max;
    int recv_gap_max;

    linear_image_warp_interpolate_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .pixel_row(pixel_row),
        .pixel_col(pixel_col),
        .pixel_in(pixel_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pixel_out(pixel_out),
        .out_of_bounds(out_of_bounds),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_request(logic cmd, logic [8:0] r, logic [8:0] c, logic [7:0] p);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command <= cmd;
        pixel_row <= r;
        pixel_col <= c;
        pixel_in <= p;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(cmd, r, c, p);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_mapping(longint rr, longint rc, longint cr, longint cc,
                               int wreg, int hreg);
        write_reg(CFG_COEF_RR, COEF_W'(rr));
        write_reg(CFG_COEF_RC, COEF_W'(rc));
        write_reg(CFG_COEF_CR, COEF_W'(cr));
        write_reg(CFG_COEF_CC, COEF_W'(cc));
        write_reg(CFG_WIDTH, {10'($urandom_range(0, 1023)), 10'(wreg)});
        write_reg(CFG_HEIGHT, {10'($urandom_range(0, 1023)), 10'(hreg)});
        cfg_valid <= 1'b0;
    endtask

    // fills the whole effective image so that every warp reads written pixels
    task automatic load_image(bit extremes);
        int w, h;
        logic [7:0] v;
        w = int'(sb.eff(sb.size_w, STORE_W));
        h = int'(sb.eff(sb.size_h, STORE_H));
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
            begin
                v = 8'($urandom_range(0, 255));
                if (extremes)
                    v = ((r + c) % 2 == 0) ? 8'd255 : 8'd0;
                send_request(CMD_LOAD, 9'(r), 9'(c), v);
            end
    endtask

    task automatic random_warps(int count);
        int w, h;
        logic [8:0] r, c;
        w = int'(sb.eff(sb.size_w, STORE_W));
        h = int'(sb.eff(sb.size_h, STORE_H));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                r = 9'($urandom_range(0, (h + 1 > 511) ? 511 : h + 1));
                c = 9'($urandom_range(0, (w + 1 > 511) ? 511 : w + 1));
            end
            else
            begin
                r = 9'($urandom_range(0, 511));
                c = 9'($urandom_range(0, 511));
            end
            send_request(CMD_WARP, r, c, 8'($urandom_range(0, 255)));
        end
    endtask

    always
    begin : receiver
        int gap;
        gap = $urandom_range(0, recv_gap_max);
        if (gap > 0)
        begin
            out_ready <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        out_ready <= 1'b1;
        do
            @(posedge clk);
        while (!(out_valid === 1'b1));
        sb.check_result(pixel_out, out_of_bounds);
        @(negedge clk);
    end

    initial
    begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int wreg, hreg;
        sb = new();
        send_gap_max = 6;
        recv_gap_max = 6;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_LOAD;
        pixel_row = '0;
        pixel_col = '0;
        pixel_in = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: identity on a 4 by 4 image with checkerboard extremes
        set_mapping(65536, 0, 0, 65536, 4, 4);
        load_image(1'b1);
        send_request(CMD_WARP, 9'd0, 9'd0, 8'd255);
        send_request(CMD_WARP, 9'd1, 9'd2, 8'd0);
        send_request(CMD_WARP, 9'd3, 9'd3, 8'd0);
        send_request(CMD_WARP, 9'd4, 9'd4, 8'd0);
        send_request(CMD_WARP, 9'd5, 9'd0, 8'd0);
        send_request(CMD_WARP, 9'd0, 9'd5, 8'd0);
        send_request(CMD_WARP, 9'd511, 9'd511, 8'd255);
        drain();
        // fractional scale, tiny distances and ignored register indexes
        write_reg(CFG_SPARE_LO, 20'hFFFFF);
        write_reg(CFG_SPARE_HI, 20'h00001);
        set_mapping(65536 + 300, 32768, -16384, 49152, 4, 4);
        send_request(CMD_WARP, 9'd2, 9'd1, 8'd0);
        send_request(CMD_WARP, 9'd3, 9'd2, 8'd0);
        send_request(CMD_WARP, 9'd1, 9'd3, 8'd0);
        drain();
        set_mapping(-524288, 524287, 524287, -524288, 4, 4);
        send_request(CMD_WARP, 9'd1, 9'd1, 8'd0);
        send_request(CMD_WARP, 9'd0, 9'd0, 8'd0);
        drain();

        // random phases; in some the sender or the receiver never idles, the rest insert random gaps
        for (int ph = 0; ph < 18; ph++)
        begin
            send_gap_max = (ph % 4 == 1) ? 0 : 6;
            recv_gap_max = (ph % 4 == 2) ? 0 : 6;
            wreg = $urandom_range(1, 10);
            hreg = $urandom_range(1, 10);
            case (ph)
                0: begin wreg = 512; hreg = 1; end
                1: begin wreg = 1; hreg = 512; end
                2: begin wreg = 0; hreg = 0; end
                3: begin wreg = 1023; hreg = 1; end
                4: begin wreg = 1; hreg = 600; end
                default: ;
            endcase
            if (ph % 6 == 5)
                set_mapping(longint'(signed'(20'($urandom))), longint'(signed'(20'($urandom))),
                            longint'(signed'(20'($urandom))), longint'(signed'(20'($urandom))),
                            wreg, hreg);
            else
                set_mapping(longint'($urandom_range(0, 131072)),
                            longint'($urandom_range(0, 65536)) - 32768,
                            longint'($urandom_range(0, 65536)) - 32768,
                            longint'($urandom_range(0, 131072)),
                            wreg, hreg);
            // row 0 and column 0 are already loaded by the first two phases
            if (ph != 3 && ph != 4)
                load_image(1'b0);
            random_warps(20);
            drain();
        end

        drain();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
